// ===== hdl/hcmm_pkg.sv =====
// ----------------------------------------------------------------------------
// hcmm_pkg - shared types and constants of the handheld console memory map
// Address map limits, store sizes, function codes and the command record
// that the front end passes to the back end.
// ----------------------------------------------------------------------------
package hcmm_pkg;

  localparam int unsigned FuncW = 3;
  localparam int unsigned BusW  = 16;
  localparam int unsigned ByteW = 8;

  // store sizes and index widths
  localparam int unsigned RomDepth   = 32768;
  localparam int unsigned BankDepth  = 8192;
  localparam int unsigned OamDepth   = 160;
  localparam int unsigned SmallDepth = 128;
  localparam int unsigned RomAw      = $clog2(RomDepth);
  localparam int unsigned BankAw     = $clog2(BankDepth);
  localparam int unsigned OamAw      = $clog2(OamDepth);
  localparam int unsigned SmallAw    = $clog2(SmallDepth);

  // queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // address map limits
  localparam logic [BusW-1:0] VramBase  = 16'h8000;
  localparam logic [BusW-1:0] EramBase  = 16'hA000;
  localparam logic [BusW-1:0] WramBase  = 16'hC000;
  localparam logic [BusW-1:0] EchoBase  = 16'hE000;
  localparam logic [BusW-1:0] EchoLast  = 16'hFDFF;
  localparam logic [BusW-1:0] OamLast   = 16'hFE9F;
  localparam logic [BusW-1:0] IoBase    = 16'hFF00;
  localparam logic [BusW-1:0] HramBase  = 16'hFF80;
  localparam logic [BusW-1:0] HramLast  = 16'hFFFE;
  localparam logic [BusW-1:0] StackStep = 16'h0002;

  typedef enum logic [FuncW-1:0] {
    FN_RD_BYTE = 3'd0,
    FN_WR_BYTE = 3'd1,
    FN_RD_WORD = 3'd2,
    FN_WR_WORD = 3'd3,
    FN_PUSH    = 3'd4,
    FN_POP     = 3'd5,
    FN_LOAD    = 3'd6
  } func_e;

  // where one byte access lands
  typedef enum logic [3:0] {
    RG_NONE,
    RG_ROM,
    RG_VRAM,
    RG_ERAM,
    RG_WRAM,
    RG_OAM,
    RG_IO,
    RG_HRAM,
    RG_IE,
    RG_BAD
  } region_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_FIRST,
    ST_SECOND,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic             is_read;
    logic             is_write;
    logic             two;
    region_e          reg0;
    region_e          reg1;
    logic [BusW-1:0]  addr0;
    logic [BusW-1:0]  addr1;
    logic [ByteW-1:0] data0;
    logic [ByteW-1:0] data1;
    logic [BusW-1:0]  sp;
  } cmd_t;

  // echo writes fold into work RAM; echo and restricted reads are errors
  function automatic region_e region_of(logic [BusW-1:0] a, logic wr);
    region_e r;
    if (a < VramBase)       r = wr ? RG_NONE : RG_ROM;
    else if (a < EramBase)  r = RG_VRAM;
    else if (a < WramBase)  r = RG_ERAM;
    else if (a < EchoBase)  r = RG_WRAM;
    else if (a <= EchoLast) r = wr ? RG_WRAM : RG_BAD;
    else if (a <= OamLast)  r = RG_OAM;
    else if (a < IoBase)    r = wr ? RG_NONE : RG_BAD;
    else if (a < HramBase)  r = RG_IO;
    else if (a <= HramLast) r = RG_HRAM;
    else                    r = RG_IE;
    return r;
  endfunction

endpackage

// ===== hdl/hcmm_if.sv =====
// ----------------------------------------------------------------------------
// hcmm_if - request and response channels of the memory map
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface hcmm_req_if;
  logic                       valid;
  logic                       ready;
  logic [hcmm_pkg::FuncW-1:0] func;
  logic [hcmm_pkg::BusW-1:0]  address;
  logic [hcmm_pkg::BusW-1:0]  write_data;
  logic [hcmm_pkg::BusW-1:0]  stack_pointer;

  modport source (output valid, func, address, write_data, stack_pointer, input ready);
  modport sink   (input valid, func, address, write_data, stack_pointer, output ready);
endinterface

interface hcmm_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [hcmm_pkg::BusW-1:0] read_data;
  logic [hcmm_pkg::BusW-1:0] new_stack_pointer;
  logic                      bad_access;

  modport source (output valid, read_data, new_stack_pointer, bad_access, input ready);
  modport sink   (input valid, read_data, new_stack_pointer, bad_access, output ready);
endinterface

// ===== hdl/hcmm_ram.sv =====
// ----------------------------------------------------------------------------
// hcmm_ram - generic single-port RAM
// One access per cycle; read data is registered and holds while idle.
// ----------------------------------------------------------------------------
module hcmm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/hcmm_front.sv =====
// ----------------------------------------------------------------------------
// hcmm_front - request classifier
// Accepts requests, works out both byte addresses, their regions, the bytes
// to write and the outgoing stack pointer, and pushes a command.
// ----------------------------------------------------------------------------
module hcmm_front (
  hcmm_req_if.sink         req,
  input  logic             clearing_i,
  input  logic             q_full_i,
  output logic             push_o,
  output hcmm_pkg::cmd_t   cmd_o
);
  import hcmm_pkg::*;

  func_e           fn;
  logic [BusW-1:0] a0;
  logic            wr;

  assign req.ready = !q_full_i && !clearing_i;
  assign push_o    = req.valid && req.ready;
  assign fn        = func_e'(req.func);

  always_comb begin
    a0           = req.address;
    wr           = 1'b0;
    cmd_o        = '0;
    cmd_o.sp     = req.stack_pointer;
    cmd_o.data0  = req.write_data[ByteW-1:0];
    cmd_o.data1  = req.write_data[ByteW-1:0];
    unique case (fn)
      FN_RD_BYTE: begin
        cmd_o.is_read = 1'b1;
      end
      FN_WR_BYTE: begin
        wr = 1'b1;
      end
      FN_RD_WORD: begin
        cmd_o.is_read = 1'b1;
        cmd_o.two     = 1'b1;
      end
      FN_WR_WORD: begin
        wr        = 1'b1;
        cmd_o.two = 1'b1;
      end
      FN_PUSH: begin
        wr        = 1'b1;
        cmd_o.two = 1'b1;
        a0        = req.stack_pointer - StackStep;
        cmd_o.sp  = a0;
      end
      FN_POP: begin
        cmd_o.is_read = 1'b1;
        cmd_o.two     = 1'b1;
        a0            = req.stack_pointer;
        cmd_o.sp      = req.stack_pointer + StackStep;
      end
      FN_LOAD: begin
        wr = 1'b1;
        a0 = {1'b0, req.address[RomAw-1:0]};
      end
      default: begin
      end
    endcase
    cmd_o.is_write = wr;
    cmd_o.addr0    = a0;
    cmd_o.addr1    = a0 + BusW'(1);
    if (cmd_o.two) begin
      cmd_o.data0 = req.write_data[BusW-1:ByteW];
    end
    if (fn == FN_LOAD) begin
      cmd_o.reg0 = RG_ROM;
    end else if (cmd_o.is_read || wr) begin
      cmd_o.reg0 = region_of(cmd_o.addr0, wr);
    end else begin
      cmd_o.reg0 = RG_NONE;
    end
    cmd_o.reg1 = cmd_o.two ? region_of(cmd_o.addr1, wr) : RG_NONE;
  end

endmodule

// ===== hdl/hcmm_queue.sv =====
// ----------------------------------------------------------------------------
// hcmm_queue - command queue between front and back
// Small FIFO; the head is visible while the back end works on it.
// ----------------------------------------------------------------------------
module hcmm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hcmm_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output hcmm_pkg::cmd_t head_o
);
  import hcmm_pkg::*;

  cmd_t             slot_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = cnt_q == QCntW'(QDepth);
  assign valid_o = cnt_q != '0;
  assign head_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

endmodule

// ===== hdl/hcmm_back.sv =====
// ----------------------------------------------------------------------------
// hcmm_back - access sequencer and stores
// Clears every store after reset, then carries out queued commands one byte
// per cycle, waiting while the output register is full, and holds the result there.
// ----------------------------------------------------------------------------
module hcmm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  hcmm_pkg::cmd_t head_i,
  output logic           pop_o,
  output logic           clearing_o,
  hcmm_rsp_if.source     rsp
);
  import hcmm_pkg::*;

  state_e            state_q, state_d;
  logic [RomAw-1:0]  clr_q;
  region_e           sel_q;
  logic [ByteW-1:0]  hi_q, ie_q;
  logic              bad_q;
  logic              rsp_valid_q;
  logic [BusW-1:0]   rsp_data_q, rsp_sp_q;
  logic              rsp_bad_q;

  logic              issue, cur_wr, load_out, clr;
  region_e           cur_reg;
  logic [BusW-1:0]   cur_addr;
  logic [ByteW-1:0]  cur_data, rd_byte;
  logic              last_bad, out_free;
  logic [BusW-1:0]   rd_word;

  logic              rom_en, vram_en, eram_en, wram_en, oam_en, io_en, hram_en;
  logic [ByteW-1:0]  rom_rd, vram_rd, eram_rd, wram_rd, oam_rd, io_rd, hram_rd;
  logic [ByteW-1:0]  wdata;
  logic              we;

  assign clr        = state_q == ST_CLEAR;
  assign clearing_o = clr;
  assign out_free   = !rsp_valid_q || rsp.ready;

  // byte now being issued
  always_comb begin
    if (state_q == ST_SECOND) begin
      cur_reg  = head_i.reg1;
      cur_addr = head_i.addr1;
      cur_data = head_i.data1;
    end else begin
      cur_reg  = head_i.reg0;
      cur_addr = head_i.addr0;
      cur_data = head_i.data0;
    end
    cur_wr = head_i.is_write;
  end

  always_comb begin
    case (sel_q)
      RG_ROM:  rd_byte = rom_rd;
      RG_VRAM: rd_byte = vram_rd;
      RG_ERAM: rd_byte = eram_rd;
      RG_WRAM: rd_byte = wram_rd;
      RG_OAM:  rd_byte = oam_rd;
      RG_IO:   rd_byte = io_rd;
      RG_HRAM: rd_byte = hram_rd;
      RG_IE:   rd_byte = ie_q;
      default: rd_byte = '0;
    endcase
  end

  assign last_bad = head_i.is_read && (bad_q || sel_q == RG_BAD);
  always_comb begin
    if (!head_i.is_read || last_bad) begin
      rd_word = '0;
    end else if (head_i.two) begin
      rd_word = {hi_q, rd_byte};
    end else begin
      rd_word = {{(BusW-ByteW){1'b0}}, rd_byte};
    end
  end

  always_comb begin
    state_d  = state_q;
    issue    = 1'b0;
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) state_d = ST_FIRST;
      end
      ST_FIRST: begin
        if (head_valid_i) begin
          issue   = 1'b1;
          state_d = head_i.two ? ST_SECOND : ST_FINISH;
        end
      end
      ST_SECOND: begin
        issue   = 1'b1;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          load_out = 1'b1;
          pop_o    = 1'b1;
          state_d  = ST_FIRST;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // store port control: clearing sweep or the issued byte
  assign we      = clr || cur_wr;
  assign wdata   = clr ? '0 : cur_data;
  assign rom_en  = clr || (issue && cur_reg == RG_ROM);
  assign vram_en = clr || (issue && cur_reg == RG_VRAM);
  assign eram_en = clr || (issue && cur_reg == RG_ERAM);
  assign wram_en = clr || (issue && cur_reg == RG_WRAM);
  assign oam_en  = (clr && clr_q[OamAw-1:0] < OamAw'(OamDepth)) || (issue && cur_reg == RG_OAM);
  assign io_en   = clr || (issue && cur_reg == RG_IO);
  assign hram_en = clr || (issue && cur_reg == RG_HRAM);

  hcmm_ram #(.Width(ByteW), .Depth(RomDepth)) u_rom (
    .clk_i, .en_i(rom_en), .we_i(we),
    .addr_i(clr ? clr_q : cur_addr[RomAw-1:0]), .wdata_i(wdata), .rdata_o(rom_rd)
  );
  hcmm_ram #(.Width(ByteW), .Depth(BankDepth)) u_vram (
    .clk_i, .en_i(vram_en), .we_i(we),
    .addr_i(clr ? clr_q[BankAw-1:0] : cur_addr[BankAw-1:0]), .wdata_i(wdata),
    .rdata_o(vram_rd)
  );
  hcmm_ram #(.Width(ByteW), .Depth(BankDepth)) u_eram (
    .clk_i, .en_i(eram_en), .we_i(we),
    .addr_i(clr ? clr_q[BankAw-1:0] : cur_addr[BankAw-1:0]), .wdata_i(wdata),
    .rdata_o(eram_rd)
  );
  hcmm_ram #(.Width(ByteW), .Depth(BankDepth)) u_wram (
    .clk_i, .en_i(wram_en), .we_i(we),
    .addr_i(clr ? clr_q[BankAw-1:0] : cur_addr[BankAw-1:0]), .wdata_i(wdata),
    .rdata_o(wram_rd)
  );
  hcmm_ram #(.Width(ByteW), .Depth(OamDepth)) u_oam (
    .clk_i, .en_i(oam_en), .we_i(we),
    .addr_i(clr ? clr_q[OamAw-1:0] : cur_addr[OamAw-1:0]), .wdata_i(wdata),
    .rdata_o(oam_rd)
  );
  hcmm_ram #(.Width(ByteW), .Depth(SmallDepth)) u_io (
    .clk_i, .en_i(io_en), .we_i(we),
    .addr_i(clr ? clr_q[SmallAw-1:0] : cur_addr[SmallAw-1:0]), .wdata_i(wdata),
    .rdata_o(io_rd)
  );
  hcmm_ram #(.Width(ByteW), .Depth(SmallDepth)) u_hram (
    .clk_i, .en_i(hram_en), .we_i(we),
    .addr_i(clr ? clr_q[SmallAw-1:0] : cur_addr[SmallAw-1:0]), .wdata_i(wdata),
    .rdata_o(hram_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      ie_q        <= '0;
      sel_q       <= RG_NONE;
      bad_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr) begin
        clr_q <= clr_q + RomAw'(1);
      end
      if (issue) begin
        sel_q <= head_i.is_read ? cur_reg : RG_NONE;
        if (cur_wr && cur_reg == RG_IE) begin
          ie_q <= cur_data;
        end
      end
      if (state_q == ST_FIRST) begin
        bad_q <= 1'b0;
      end else if (state_q == ST_SECOND) begin
        bad_q <= sel_q == RG_BAD;
      end
      if (load_out) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SECOND) begin
      hi_q <= rd_byte;
    end
    if (load_out) begin
      rsp_data_q <= rd_word;
      rsp_sp_q   <= head_i.sp;
      rsp_bad_q  <= last_bad;
    end
  end

  assign rsp.valid             = rsp_valid_q;
  assign rsp.read_data         = rsp_data_q;
  assign rsp.new_stack_pointer = rsp_sp_q;
  assign rsp.bad_access        = rsp_bad_q;

endmodule

// ===== hdl/handheld_console_memory_map.sv =====
// ----------------------------------------------------------------------------
// handheld_console_memory_map - 16-bit memory map of a handheld console
// Byte, big-endian word, push, pop and ROM load accesses onto eight stores.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries func, address, write_data and stack_pointer; rsp_o returns
//   read_data, new_stack_pointer and bad_access, one response per request,
//   in order. Both are valid/ready channels.
//   After reset a clearing sweep zeroes every store, one ROM entry (and the
//   matching entry of each smaller store) per cycle. req_i ready stays low
//   until it finishes.
//   The front end decodes each request into a two-entry command queue; the
//   back end then works one byte per cycle, waiting while rsp_o still holds
//   an untaken result, on single-port byte RAMs with registered read data.
//   Each command steps through the first-byte state, the second-byte state
//   for word reads/writes, push and pop, and the finish state that loads
//   the output reg. The back end ends one command before it starts the
//   next; the byte-wide single RAM port takes one byte per access.
//   A stalled rsp_o holds its item; the back end waits on the next result
//   while the queue keeps taking requests until it is full.
// ----------------------------------------------------------------------------
module handheld_console_memory_map (
  input  logic       clk_i,
  input  logic       rst_ni,
  hcmm_req_if.sink   req_i,
  hcmm_rsp_if.source rsp_o
);
  import hcmm_pkg::*;

  cmd_t cmd, head;
  logic push, pop, q_full, head_valid, clearing;

  // classify requests
  hcmm_front u_front (
    .req        (req_i),
    .clearing_i (clearing),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  // decouples acceptance from the byte sequencer
  hcmm_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  // stores, byte sequencer and response register
  hcmm_back u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .rsp          (rsp_o)
  );

endmodule
